// ----- hw/rtl/rv32i_instruction_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// RV32I instruction decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RVID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rvid_pkg.sv -----
// ----------------------------------------------------------------------------
// RV32I instruction decoder package
// Item types, opcode and operation codes shared by the decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

  // Major opcodes, instruction bits 6..0
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  typedef enum logic [5:0] {
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
    OP_SB, OP_SH, OP_SW,
    OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
    OP_SLLI, OP_SRLI, OP_SRAI,
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
    OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_ECALL, OP_EBREAK,
    OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI,
    OP_ILLEGAL
  } op_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] fetch_address;
  } in_item_t;

  typedef struct packed {
    op_e                op_kind;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic [11:0]        csr_number;
    logic [31:0]        jump_target;
  } out_item_t;

endpackage

// ----- hw/rtl/rv32i_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// RV32I instruction decoder
// Decodes one instruction word per cycle, while the output is not stalled,
// into operation, fields, immediate and branch/jal target.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with in_item_i (instruction word and
// its fetch address). Output channel: out_valid_o / out_stall_i with
// out_item_o. An item moves at a rising edge with valid high and stall low.
// The word lands in an input register; decode, immediate assembly and the
// target add run in one pass into the result register.
// After acceptance an item passes through the input register and then the
// result register, which drives out_item_o together with out_valid_o.
// Throughput: 1 item per cycle while out_stall_i is low; the target adder is the longest path.
// When the receiver stalls, the result is held and one more item is taken
// into the input register; in_stall_o rises only when both stages are full.
// Reset empties both stages; no other state is kept.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_decoder_defines.svh"

module rv32i_instruction_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rvid_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rvid_pkg::out_item_t out_item_o
);
  import rvid_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t dec;

  logic out_ready;
  logic s1_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;

  assign in_stall_o  = !s1_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Decode
  logic [31:0] w;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh, imm_z;
  logic [31:0] imm;
  logic        jumps;

  assign w   = s1_item_q.instruction;
  assign opc = w[6:0];
  assign f3  = w[14:12];
  assign f7  = w[31:25];

  assign imm_i  = {{20{w[31]}}, w[31:20]};
  assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u  = {w[31:12], 12'b0};
  assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_sh = {27'b0, w[24:20]};
  assign imm_z  = {27'b0, w[19:15]};

  always_comb begin
    dec            = '0;
    dec.op_kind    = OP_ILLEGAL;
    dec.dest_reg   = w[11:7];
    dec.src_reg_a  = w[19:15];
    dec.src_reg_b  = w[24:20];
    imm            = '0;
    jumps          = 1'b0;

    unique case (opc)
      OPC_LUI: begin
        dec.op_kind = OP_LUI;
        imm         = imm_u;
      end
      OPC_AUIPC: begin
        dec.op_kind = OP_AUIPC;
        imm         = imm_u;
      end
      OPC_JAL: begin
        dec.op_kind = OP_JAL;
        imm         = imm_j;
        jumps       = 1'b1;
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          dec.op_kind = OP_JALR;
          imm         = imm_i;
        end
      end
      OPC_BRANCH: begin
        unique case (f3)
          3'd0:    dec.op_kind = OP_BEQ;
          3'd1:    dec.op_kind = OP_BNE;
          3'd4:    dec.op_kind = OP_BLT;
          3'd5:    dec.op_kind = OP_BGE;
          3'd6:    dec.op_kind = OP_BLTU;
          3'd7:    dec.op_kind = OP_BGEU;
          default: dec.op_kind = OP_ILLEGAL;
        endcase
        if (dec.op_kind != OP_ILLEGAL) begin
          imm   = imm_b;
          jumps = 1'b1;
        end
      end
      OPC_LOAD: begin
        unique case (f3)
          3'd0:    dec.op_kind = OP_LB;
          3'd1:    dec.op_kind = OP_LH;
          3'd2:    dec.op_kind = OP_LW;
          3'd4:    dec.op_kind = OP_LBU;
          3'd5:    dec.op_kind = OP_LHU;
          default: dec.op_kind = OP_ILLEGAL;
        endcase
        if (dec.op_kind != OP_ILLEGAL) imm = imm_i;
      end
      OPC_STORE: begin
        unique case (f3)
          3'd0:    dec.op_kind = OP_SB;
          3'd1:    dec.op_kind = OP_SH;
          3'd2:    dec.op_kind = OP_SW;
          default: dec.op_kind = OP_ILLEGAL;
        endcase
        if (dec.op_kind != OP_ILLEGAL) imm = imm_s;
      end
      OPC_OP_IMM: begin
        unique case (f3)
          3'd0: begin dec.op_kind = OP_ADDI;  imm = imm_i; end
          3'd2: begin dec.op_kind = OP_SLTI;  imm = imm_i; end
          3'd3: begin dec.op_kind = OP_SLTIU; imm = imm_i; end
          3'd4: begin dec.op_kind = OP_XORI;  imm = imm_i; end
          3'd6: begin dec.op_kind = OP_ORI;   imm = imm_i; end
          3'd7: begin dec.op_kind = OP_ANDI;  imm = imm_i; end
          3'd1: begin
            if (f7 == F7_BASE) begin
              dec.op_kind = OP_SLLI;
              imm         = imm_sh;
            end
          end
          default: begin
            if (f7 == F7_BASE) begin
              dec.op_kind = OP_SRLI;
              imm         = imm_sh;
            end else if (f7 == F7_ALT) begin
              dec.op_kind = OP_SRAI;
              imm         = imm_sh;
            end
          end
        endcase
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0:    dec.op_kind = OP_ADD;
            3'd1:    dec.op_kind = OP_SLL;
            3'd2:    dec.op_kind = OP_SLT;
            3'd3:    dec.op_kind = OP_SLTU;
            3'd4:    dec.op_kind = OP_XOR;
            3'd5:    dec.op_kind = OP_SRL;
            3'd6:    dec.op_kind = OP_OR;
            default: dec.op_kind = OP_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0)      dec.op_kind = OP_SUB;
          else if (f3 == 3'd5) dec.op_kind = OP_SRA;
        end
      end
      OPC_SYSTEM: begin
        unique case (f3)
          3'd0: begin
            // only the exact ecall and ebreak words are legal
            if (w == WORD_ECALL)       dec.op_kind = OP_ECALL;
            else if (w == WORD_EBREAK) dec.op_kind = OP_EBREAK;
          end
          3'd1: begin dec.op_kind = OP_CSRRW;  dec.csr_number = w[31:20]; end
          3'd2: begin dec.op_kind = OP_CSRRS;  dec.csr_number = w[31:20]; end
          3'd3: begin dec.op_kind = OP_CSRRC;  dec.csr_number = w[31:20]; end
          3'd5: begin
            dec.op_kind = OP_CSRRWI; dec.csr_number = w[31:20]; imm = imm_z;
          end
          3'd6: begin
            dec.op_kind = OP_CSRRSI; dec.csr_number = w[31:20]; imm = imm_z;
          end
          3'd7: begin
            dec.op_kind = OP_CSRRCI; dec.csr_number = w[31:20]; imm = imm_z;
          end
          default: dec.op_kind = OP_ILLEGAL;
        endcase
      end
      default: dec.op_kind = OP_ILLEGAL;
    endcase

    dec.immediate   = $signed(imm);
    dec.jump_target = jumps ? (s1_item_q.fetch_address + imm) : 32'd0;
  end

  // Handshake control
  always_comb begin
    s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load only on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_item_q <= in_item_i;
    end
    if (s1_valid_q && out_ready) begin
      out_item_q <= dec;
    end
  end

  `RVID_ASSERT_SAME(a_stall_only_when_full, in_stall_o,
    s1_valid_q && out_valid_q && out_stall_i, "input stalled with a free stage")

  `RVID_ASSERT_NEXT(a_s1_advances, s1_valid_q && out_ready,
    out_valid_q, "decoded item lost on advance")

  `RVID_ASSERT_SAME(a_illegal_clean, out_valid_q && out_item_q.op_kind == OP_ILLEGAL,
    out_item_q.immediate == 0 && out_item_q.csr_number == 0 && out_item_q.jump_target == 0,
    "illegal item carries immediate, csr or target")

  `RVID_ASSERT_SAME(a_target_only_jumps, out_valid_q && out_item_q.jump_target != 0,
    out_item_q.op_kind == OP_JAL || out_item_q.op_kind == OP_BEQ ||
    out_item_q.op_kind == OP_BNE || out_item_q.op_kind == OP_BLT ||
    out_item_q.op_kind == OP_BGE || out_item_q.op_kind == OP_BLTU ||
    out_item_q.op_kind == OP_BGEU, "target set for a non-jump operation")

endmodule
